FILE: hw/rtl/pns_pkg.sv
package pns_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    CFG_MIDI_CHANNEL  = 3'd0,
    CFG_LOW_NOTE      = 3'd1,
    CFG_HIGH_NOTE     = 3'd2,
    CFG_RESPONSE_MODE = 3'd3,
    CFG_SENSITIVITY   = 3'd4
  } cfg_reg_e;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 9;

  // Reset values of the registers
  localparam logic [3:0] RstChanNibble = 4'd0;   // channel 1
  localparam logic [6:0] RstLowNote    = 7'd12;
  localparam logic [6:0] RstHighNote   = 7'd108;
  localparam logic [1:0] RstConfirm    = 2'd2;
  localparam logic [2:0] RstRelease    = 3'd3;
  localparam logic [8:0] RstSens       = 9'd90;

  // Onset and envelope constants
  localparam logic [1:0]  RefractoryFrames = 2'd3;
  localparam logic [8:0]  EnvOnsetMul      = 9'd435;    // 1.7 in Q8
  localparam logic [13:0] EnvRate          = 14'd13107; // 0.2 in Q16

  // Velocity constants
  localparam logic [13:0] VelScaleSq = 14'd12100;  // 110 squared
  localparam logic [6:0]  VelBase    = 7'd17;
  localparam logic [16:0] VelArgMax  = 17'd65536;  // 1.0 in Q16

  // One input beat
  typedef struct packed {
    logic        pitch_valid;
    logic [14:0] pitch_note;
    logic [15:0] clarity;
    logic [15:0] level;
    logic [11:0] block_end_offset;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic              note_off_valid;
    logic [6:0]        note_off_number;
    logic              note_on_valid;
    logic [6:0]        note_on_number;
    logic [6:0]        note_on_velocity;
    logic [3:0]        channel_nibble;
    logic [11:0]       event_offset;
    logic signed [7:0] held_note;
    logic [15:0]       shown_level;
    logic [14:0]       shown_pitch;
  } out_beat_t;

  // Input stage: the beat plus the velocity radicand taken at accept
  typedef struct packed {
    in_beat_t    beat;
    logic [13:0] vel_rad;
  } stage_t;

  // Working configuration handed to the core
  typedef struct packed {
    logic [3:0]  chan_nibble;
    logic [6:0]  low_note;
    logic [7:0]  high_eff;
    logic [1:0]  confirm;
    logic [2:0]  release_cnt;
    logic [10:0] level_floor;
    logic [15:0] clarity_min;
  } cfg_t;

  // Level floor: 98 + floor((256 - s) * 1311 / 256), s clamped to 256
  function automatic logic [10:0] level_floor(input logic [8:0] sens);
    logic [8:0]  s;
    logic [8:0]  inv;
    logic [19:0] prod;
    s    = (sens > 9'd256) ? 9'd256 : sens;
    inv  = 9'd256 - s;
    prod = 20'(inv) * 20'd1311;
    return 11'd98 + 11'(prod[19:8]);
  endfunction

  // Minimum clarity: 32768 + floor((256 - s) * 19661 / 256)
  function automatic logic [15:0] clarity_min(input logic [8:0] sens);
    logic [8:0]  s;
    logic [8:0]  inv;
    logic [22:0] prod;
    s    = (sens > 9'd256) ? 9'd256 : sens;
    inv  = 9'd256 - s;
    prod = 23'(inv) * 23'd19661;
    return 16'd32768 + {1'b0, prod[22:8]};
  endfunction

endpackage

FILE: hw/rtl/pns_cfg.sv
module pns_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pns_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [pns_pkg::CfgDataWidth-1:0]    cfg_data_i,
  output pns_pkg::cfg_t                       cfg_o
);

  logic [3:0]  chan_q;
  logic [6:0]  low_q;
  logic [6:0]  high_q;
  logic [1:0]  confirm_q;
  logic [2:0]  release_q;
  logic [10:0] lfloor_q;
  logic [15:0] cmin_q;
  logic [4:0]  chan_wr;
  logic [7:0]  low_plus1;

  assign cfg_ready_o = 1'b1;
  assign chan_wr     = cfg_data_i[4:0];

  // Register writes; derived values are stored at write time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q    <= pns_pkg::RstChanNibble;
      low_q     <= pns_pkg::RstLowNote;
      high_q    <= pns_pkg::RstHighNote;
      confirm_q <= pns_pkg::RstConfirm;
      release_q <= pns_pkg::RstRelease;
      lfloor_q  <= pns_pkg::level_floor(pns_pkg::RstSens);
      cmin_q    <= pns_pkg::clarity_min(pns_pkg::RstSens);
    end else if (cfg_valid_i) begin
      unique case (pns_pkg::cfg_reg_e'(cfg_index_i))
        pns_pkg::CFG_MIDI_CHANNEL: begin
          // channel 0 acts as 1, above 16 acts as 16
          if (chan_wr == 5'd0) chan_q <= 4'd0;
          else if (chan_wr > 5'd16) chan_q <= 4'd15;
          else chan_q <= 4'(chan_wr - 5'd1);
        end
        pns_pkg::CFG_LOW_NOTE:  low_q  <= cfg_data_i[6:0];
        pns_pkg::CFG_HIGH_NOTE: high_q <= cfg_data_i[6:0];
        pns_pkg::CFG_RESPONSE_MODE: begin
          case (cfg_data_i[1:0])
            2'd0: begin
              confirm_q <= 2'd1;
              release_q <= 3'd2;
            end
            2'd2: begin
              confirm_q <= 2'd3;
              release_q <= 3'd4;
            end
            default: begin
              confirm_q <= 2'd2;
              release_q <= 3'd3;
            end
          endcase
        end
        pns_pkg::CFG_SENSITIVITY: begin
          lfloor_q <= pns_pkg::level_floor(cfg_data_i);
          cmin_q   <= pns_pkg::clarity_min(cfg_data_i);
        end
        default: ;
      endcase
    end
  end

  // High note is raised to at least low note plus one
  assign low_plus1 = {1'b0, low_q} + 8'd1;

  always_comb begin
    cfg_o.chan_nibble = chan_q;
    cfg_o.low_note    = low_q;
    cfg_o.high_eff    = ({1'b0, high_q} < low_plus1) ? low_plus1 : {1'b0, high_q};
    cfg_o.confirm     = confirm_q;
    cfg_o.release_cnt = release_q;
    cfg_o.level_floor = lfloor_q;
    cfg_o.clarity_min = cmin_q;
  end

endmodule

FILE: hw/rtl/pns_isqrt.sv
module pns_isqrt (
  input  logic [13:0] rad_i,
  output logic [6:0]  root_o
);

  // Digit-by-digit integer square root, two radicand bits per step
  always_comb begin
    logic [15:0] rem;
    logic [15:0] trial;
    logic [6:0]  root;
    rem  = 16'd0;
    root = 7'd0;
    for (int i = 6; i >= 0; i--) begin
      rem   = {rem[13:0], rad_i[2*i +: 2]};
      trial = {7'd0, root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[5:0], 1'b1};
      end else begin
        root = {root[5:0], 1'b0};
      end
    end
    root_o = root;
  end

endmodule

FILE: hw/rtl/pns_core.sv
module pns_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  pns_pkg::stage_t    stage_i,
  input  pns_pkg::cfg_t      cfg_i,
  output pns_pkg::out_beat_t res_o
);

  // Tracking state
  logic        held_v_q, held_v_d;
  logic [6:0]  held_q, held_d;
  logic        cand_v_q, cand_v_d;
  logic [6:0]  cand_q, cand_d;
  logic [2:0]  cand_cnt_q, cand_cnt_d;
  logic [2:0]  silent_q, silent_d;
  logic [6:0]  hist_q [2];
  logic [6:0]  hist_d [2];
  logic [1:0]  fill_q, fill_d;
  logic [15:0] env_q, env_d;
  logic [1:0]  refr_q, refr_d;

  logic [14:0] pitch;
  logic [15:0] level;
  logic        voiced;
  logic        onset;
  logic [15:0] hi_lim;
  logic [24:0] env_mul;
  logic [17:0] thr;
  logic        env_up;
  logic [15:0] env_diff;
  logic [29:0] env_dmul;
  logic [13:0] env_step;
  logic [15:0] raw_sum;
  logic [7:0]  raw8;
  logic [6:0]  hcap;
  logic [6:0]  raw;
  logic [6:0]  med_a, med_b, med;
  logic [1:0]  fill_inc;
  logic [6:0]  note;
  logic [6:0]  root;

  assign pitch = stage_i.beat.pitch_note;
  assign level = stage_i.beat.level;

  // Voicing test: widened note range, level and clarity floors
  assign hi_lim = {cfg_i.high_eff, 8'd0} + 16'd87;
  assign voiced = stage_i.beat.pitch_valid
                  && (({1'b0, pitch} + 16'd89) >= {1'b0, cfg_i.low_note, 8'd0})
                  && ({1'b0, pitch} <= hi_lim)
                  && (level > {5'd0, cfg_i.level_floor})
                  && (stage_i.beat.clarity > cfg_i.clarity_min);

  // Onset against the envelope before its update
  assign env_mul = 25'(env_q) * 25'(pns_pkg::EnvOnsetMul);
  assign thr     = {1'b0, env_mul[24:8]} + {6'd0, cfg_i.level_floor, 1'b0};
  assign onset   = ({2'b00, level} > thr) && (refr_q == 2'd0);

  // Envelope moves a fifth of the way toward the level
  assign env_up   = level >= env_q;
  assign env_diff = env_up ? (level - env_q) : (env_q - level);
  assign env_dmul = 30'(env_diff) * 30'(pns_pkg::EnvRate);
  assign env_step = env_dmul[29:16];

  // Round to a note and clamp to the range
  assign raw_sum = {1'b0, pitch} + 16'd128;
  assign raw8    = raw_sum[15:8];
  assign hcap    = (cfg_i.high_eff > 8'd127) ? 7'd127 : cfg_i.high_eff[6:0];

  always_comb begin
    if (raw8 < {1'b0, cfg_i.low_note}) raw = cfg_i.low_note;
    else if (raw8 > {1'b0, hcap}) raw = hcap;
    else raw = raw8[6:0];
  end

  // Three-note median over the new note and the last two
  assign med_a    = (raw < hist_q[0]) ? raw : hist_q[0];
  assign med_b    = (raw > hist_q[0]) ? raw : hist_q[0];
  assign med      = (med_a > ((med_b < hist_q[1]) ? med_b : hist_q[1]))
                    ? med_a : ((med_b < hist_q[1]) ? med_b : hist_q[1]);
  assign fill_inc = (fill_q == 2'd3) ? 2'd3 : fill_q + 2'd1;
  assign note     = (fill_inc == 2'd3) ? med : raw;

  pns_isqrt u_isqrt (
    .rad_i  (stage_i.vel_rad),
    .root_o (root)
  );

  // Note decisions and the result beat
  always_comb begin
    held_v_d   = held_v_q;
    held_d     = held_q;
    cand_v_d   = cand_v_q;
    cand_d     = cand_q;
    cand_cnt_d = cand_cnt_q;
    silent_d   = silent_q;
    hist_d     = hist_q;
    fill_d     = fill_q;
    env_d      = env_up ? (env_q + {2'd0, env_step}) : (env_q - {2'd0, env_step});
    refr_d     = (refr_q != 2'd0) ? refr_q - 2'd1 : refr_q;

    res_o.note_off_valid   = 1'b0;
    res_o.note_off_number  = 7'd0;
    res_o.note_on_valid    = 1'b0;
    res_o.note_on_number   = 7'd0;
    res_o.note_on_velocity = 7'd0;
    res_o.channel_nibble   = cfg_i.chan_nibble;
    res_o.event_offset     = stage_i.beat.block_end_offset;
    res_o.shown_level      = (level[15:14] != 2'b00) ? 16'hFFFF : {level[13:0], 2'b00};
    res_o.shown_pitch      = voiced ? pitch : 15'd0;

    if (voiced) begin
      silent_d  = 3'd0;
      hist_d[0] = raw;
      hist_d[1] = hist_q[0];
      fill_d    = fill_inc;
      if (cand_v_q && (note == cand_q)) begin
        if (cand_cnt_q != 3'd7) cand_cnt_d = cand_cnt_q + 3'd1;
      end else begin
        cand_v_d   = 1'b1;
        cand_d     = note;
        cand_cnt_d = 3'd1;
      end
      if (!held_v_q) begin
        if (cand_cnt_d >= {1'b0, cfg_i.confirm}) begin
          held_v_d            = 1'b1;
          held_d              = note;
          res_o.note_on_valid = 1'b1;
        end
      end else if (((note != held_q) && (cand_cnt_d >= {1'b0, cfg_i.confirm})) || onset) begin
        // change of note or onset retrigger
        res_o.note_off_valid  = 1'b1;
        res_o.note_off_number = held_q;
        held_d                = note;
        res_o.note_on_valid   = 1'b1;
      end
      if (res_o.note_on_valid) begin
        res_o.note_on_number   = note;
        res_o.note_on_velocity = root + pns_pkg::VelBase;
        refr_d                 = pns_pkg::RefractoryFrames;
      end
    end else begin
      cand_cnt_d = 3'd0;
      fill_d     = 2'd0;
      if (held_v_q) begin
        if (silent_q != 3'd7) silent_d = silent_q + 3'd1;
        if (silent_d >= cfg_i.release_cnt) begin
          res_o.note_off_valid  = 1'b1;
          res_o.note_off_number = held_q;
          held_v_d              = 1'b0;
          res_o.shown_pitch     = 15'd0;
        end
      end
    end

    res_o.held_note = held_v_d ? $signed({1'b0, held_d}) : -8'sd1;
  end

  // State advances once per frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_v_q   <= 1'b0;
      held_q     <= 7'd0;
      cand_v_q   <= 1'b0;
      cand_q     <= 7'd0;
      cand_cnt_q <= 3'd0;
      silent_q   <= 3'd0;
      hist_q[0]  <= 7'd0;
      hist_q[1]  <= 7'd0;
      fill_q     <= 2'd0;
      env_q      <= 16'd0;
      refr_q     <= 2'd0;
    end else if (step_i) begin
      held_v_q   <= held_v_d;
      held_q     <= held_d;
      cand_v_q   <= cand_v_d;
      cand_q     <= cand_d;
      cand_cnt_q <= cand_cnt_d;
      silent_q   <= silent_d;
      hist_q     <= hist_d;
      fill_q     <= fill_d;
      env_q      <= env_d;
      refr_q     <= refr_d;
    end
  end

endmodule

FILE: hw/rtl/pitch_to_note_segmenter.sv
// Pitch-to-note segmenter. Takes one tracker frame per clock unless stalled
// and returns one result beat per frame: a note-off slot, a note-on slot
// with velocity, and the display values. A frame passes an input register,
// then the note logic, then a result register; the held-note, median and
// envelope state updates as each frame leaves the input register, which
// sets the rate at one frame per cycle while the output is not stalled.
// While a result waits on a stalled output, the input register takes one
// more frame and then the input stalls until the result leaves.
// Configuration writes are always ready and take effect on the next frame;
// write them while no frame is in flight.
module pitch_to_note_segmenter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pns_pkg::in_beat_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pns_pkg::out_beat_t                out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pns_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [pns_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  pns_pkg::cfg_t      cfg;
  pns_pkg::stage_t    stage_q, stage_d;
  logic               stage_v_q;
  pns_pkg::out_beat_t res;
  pns_pkg::out_beat_t out_q;
  logic               out_v_q;
  logic               adv;
  logic               in_acc;
  logic [18:0]        lvl6;
  logic [16:0]        vel_arg;
  logic [29:0]        vel_prod;

  pns_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: the stage moves on when the result register is free
  assign adv        = stage_v_q && (!out_v_q || !out_stall_i);
  assign in_stall_o = stage_v_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Velocity radicand: floor(12100 * min(6 * level, 1.0) / 65536)
  assign lvl6     = 19'(in_data_i.level) * 19'd6;
  assign vel_arg  = (lvl6 > 19'(pns_pkg::VelArgMax)) ? pns_pkg::VelArgMax : lvl6[16:0];
  assign vel_prod = 30'(vel_arg) * 30'(pns_pkg::VelScaleSq);

  always_comb begin
    stage_d.beat    = in_data_i;
    stage_d.vel_rad = vel_prod[29:16];
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else if (in_acc) begin
      stage_v_q <= 1'b1;
    end else if (adv) begin
      stage_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stage_q <= stage_d;
    end
  end

  pns_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv),
    .stage_i (stage_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // A note-on always carries a velocity of at least the base value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.note_on_valid |->
      out_data_o.note_on_velocity >= pns_pkg::VelBase)
    else $error("note-on velocity below base");

  // After a note-on the held note is that note
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.note_on_valid |->
      out_data_o.held_note == $signed({1'b0, out_data_o.note_on_number}))
    else $error("held note differs from note-on");

  // An unused note-on slot reports zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.note_on_valid |->
      out_data_o.note_on_velocity == 7'd0 && out_data_o.note_on_number == 7'd0)
    else $error("unused note-on slot not cleared");

  // The input side only stalls with a frame held in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(in_acc) || $past(in_stall_o))
    else $error("stall without a held frame");

endmodule

FILE: tb/sv/pitch_to_note_segmenter_test.sv
`timescale 1ns / 1ps

module pitch_to_note_segmenter_test;
  import pns_pkg::*;

  localparam int IdlePct       = 18;
  localparam int WatchdogLimit = 4000;
  localparam int Phases        = 10;
  localparam int PhaseFrames   = 145;

  // Response modes as written to the register
  localparam logic [1:0] MODE_QUICK   = 2'd0;
  localparam logic [1:0] MODE_STEADY  = 2'd1;
  localparam logic [1:0] MODE_CAREFUL = 2'd2;
  localparam logic [1:0] MODE_SPARE   = 2'd3;

  typedef enum bit {ROW_FRAME, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e kind;
    cfg_reg_e  idx;
    int        val;
    in_beat_t  beat;
    bit        known;
    out_beat_t res;
  } plan_row_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  in_beat_t   in_data   = '0;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  cfg_reg_e   cfg_index = CFG_MIDI_CHANNEL;
  logic [8:0] cfg_data  = '0;
  logic       in_stall;
  logic       out_valid;
  out_beat_t  out_data;
  logic       cfg_ready;

  // Typed expectation riding along with the frame on the bus
  bit        pin_known = 1'b0;
  out_beat_t pin_res   = '0;

  bit calm = 1'b0;
  int frames_sent  = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;
  out_beat_t awaited_results[$];

  // Register copy, reset values
  int unsigned cfg_chan = 1;
  int unsigned cfg_lo   = 12;
  int unsigned cfg_hi   = 108;
  logic [1:0]  cfg_mode = MODE_STEADY;
  int unsigned cfg_sens = 90;

  // Segmenter state, reset values
  int          held_st    = -1;
  int          cand_note  = -1;
  int unsigned cand_cnt   = 0;
  int unsigned quiet_cnt  = 0;
  int          hist[3]    = '{-1, -1, -1};
  int unsigned hist_fill  = 0;
  int unsigned env_lvl    = 0;
  int unsigned refr_left  = 0;

  pitch_to_note_segmenter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int unsigned level_floor_of(int unsigned sens);
    int unsigned s;
    s = (sens > 256) ? 256 : sens;
    return 98 + (((256 - s) * 1311) >> 8);
  endfunction

  function automatic int unsigned clarity_min_of(int unsigned sens);
    int unsigned s;
    s = (sens > 256) ? 256 : sens;
    return 32768 + (((256 - s) * 19661) >> 8);
  endfunction

  // One frame through the segmenter: advances state, returns the result beat
  function automatic out_beat_t segment_frame(in_beat_t b);
    out_beat_t         r;
    int unsigned       chan, lo, hi, hcap, conf, rel, lf, cm, thr, lvl;
    int                pit, rnd, note, a, c;
    bit                voiced, onset, on_v;
    longint unsigned   arg, rhs, k;
    r    = '0;
    on_v = 1'b0;
    chan = cfg_chan;
    if (chan < 1) chan = 1;
    if (chan > 16) chan = 16;
    lo = cfg_lo;
    hi = cfg_hi;
    if (hi < lo + 1) hi = lo + 1;
    case (cfg_mode)
      MODE_QUICK: begin
        conf = 1;
        rel  = 2;
      end
      MODE_CAREFUL: begin
        conf = 3;
        rel  = 4;
      end
      default: begin
        conf = 2;
        rel  = 3;
      end
    endcase
    lf  = level_floor_of(cfg_sens);
    cm  = clarity_min_of(cfg_sens);
    pit = int'(b.pitch_note);
    lvl = b.level;

    voiced = b.pitch_valid && pit >= int'(lo * 256) - 89 && pit <= int'(hi * 256) + 87
             && lvl > lf && b.clarity > cm;

    // Onset against the envelope as it stood before this frame
    thr   = ((env_lvl * 435) >> 8) + 2 * lf;
    onset = lvl > thr && refr_left == 0;
    if (lvl >= env_lvl) env_lvl += ((lvl - env_lvl) * 13107) >> 16;
    else env_lvl -= ((env_lvl - lvl) * 13107) >> 16;
    if (refr_left > 0) refr_left--;

    r.shown_level = (lvl * 4 > 65535) ? 16'hFFFF : 16'(lvl * 4);
    r.shown_pitch = voiced ? b.pitch_note : 15'd0;

    if (voiced) begin
      hcap = (hi > 127) ? 127 : hi;
      rnd  = (pit + 128) / 256;
      if (rnd < int'(lo)) rnd = lo;
      if (rnd > int'(hcap)) rnd = hcap;
      quiet_cnt = 0;
      // three-note median, raw note until the history is full
      hist[2] = hist[1];
      hist[1] = hist[0];
      hist[0] = rnd;
      if (hist_fill < 3) hist_fill++;
      if (hist_fill < 3) begin
        note = rnd;
      end else begin
        a = (hist[0] < hist[1]) ? hist[0] : hist[1];
        c = (hist[0] > hist[1]) ? hist[0] : hist[1];
        c = (c < hist[2]) ? c : hist[2];
        note = (a > c) ? a : c;
      end
      if (note == cand_note) begin
        if (cand_cnt < 7) cand_cnt++;
      end else begin
        cand_note = note;
        cand_cnt  = 1;
      end
      if (held_st < 0) begin
        if (cand_cnt >= conf) begin
          held_st = note;
          on_v    = 1'b1;
        end
      end else if ((note != held_st && cand_cnt >= conf) || (onset && cand_cnt >= 1)) begin
        r.note_off_valid  = 1'b1;
        r.note_off_number = 7'(held_st);
        held_st = note;
        on_v    = 1'b1;
      end
      if (on_v) begin
        r.note_on_valid  = 1'b1;
        r.note_on_number = 7'(held_st);
        // largest k with k^2 <= 12100 * min(6 * level, 1.0)
        arg = longint'(lvl) * 6;
        if (arg > 65536) arg = 65536;
        rhs = arg * 12100;
        k   = 0;
        while (k < 110 && (k + 1) * (k + 1) * 65536 <= rhs) k++;
        r.note_on_velocity = 7'(k + 17);
        refr_left = RefractoryFrames;
      end
    end else begin
      cand_cnt  = 0;
      hist_fill = 0;
      if (held_st >= 0) begin
        if (quiet_cnt < 7) quiet_cnt++;
        if (quiet_cnt >= rel) begin
          r.note_off_valid  = 1'b1;
          r.note_off_number = 7'(held_st);
          held_st       = -1;
          r.shown_pitch = 15'd0;
        end
      end
    end

    r.channel_nibble = 4'(chan - 1);
    r.event_offset   = b.block_end_offset;
    r.held_note      = 8'(held_st);
    return r;
  endfunction

  task automatic check_field(string name, longint got, longint want);
    if (got != want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d field %s: expected %0d, got %0d", results_seen, name, want, got);
    end
  endtask

  // Result checking and prediction at each edge
  always @(posedge clk) begin : result_check
    out_beat_t want;
    out_beat_t pred;
    if (out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing pending: %h", results_seen, out_data);
      end else begin
        want = awaited_results.pop_front();
        check_field("note_off_valid", out_data.note_off_valid, want.note_off_valid);
        check_field("note_off_number", out_data.note_off_number, want.note_off_number);
        check_field("note_on_valid", out_data.note_on_valid, want.note_on_valid);
        check_field("note_on_number", out_data.note_on_number, want.note_on_number);
        check_field("note_on_velocity", out_data.note_on_velocity, want.note_on_velocity);
        check_field("channel_nibble", out_data.channel_nibble, want.channel_nibble);
        check_field("event_offset", out_data.event_offset, want.event_offset);
        check_field("held_note", $signed(out_data.held_note), $signed(want.held_note));
        check_field("shown_level", out_data.shown_level, want.shown_level);
        check_field("shown_pitch", out_data.shown_pitch, want.shown_pitch);
      end
      results_seen++;
    end
    if (in_valid && !in_stall) begin
      pred = segment_frame(in_data);
      awaited_results.push_back(pin_known ? pin_res : pred);
    end
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IdlePct);
  end

  task automatic send_frame(in_beat_t b, bit known, out_beat_t res);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= b;
    pin_known <= known;
    pin_res   <= res;
    do @(posedge clk); while (in_stall);
    frames_sent++;
  endtask

  // Wait until every frame has produced its result, then a little longer
  task automatic settle();
    in_valid <= 1'b0;
    while (results_seen < frames_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 9'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MIDI_CHANNEL:  cfg_chan = val & 31;
      CFG_LOW_NOTE:      cfg_lo   = val & 127;
      CFG_HIGH_NOTE:     cfg_hi   = val & 127;
      CFG_RESPONSE_MODE: cfg_mode = 2'(val);
      CFG_SENSITIVITY:   cfg_sens = val & 511;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic plan_row_t frame_row(int pv, int pitch, int clar, int lvl, int ofs);
    plan_row_t row;
    row.kind                  = ROW_FRAME;
    row.idx                   = CFG_MIDI_CHANNEL;
    row.val                   = 0;
    row.beat.pitch_valid      = pv[0];
    row.beat.pitch_note       = 15'(pitch);
    row.beat.clarity          = 16'(clar);
    row.beat.level            = 16'(lvl);
    row.beat.block_end_offset = 12'(ofs);
    row.known                 = 1'b0;
    row.res                   = '0;
    return row;
  endfunction

  function automatic plan_row_t reg_row(cfg_reg_e idx, int val);
    plan_row_t row;
    row      = frame_row(0, 0, 0, 0, 0);
    row.kind = ROW_REG;
    row.idx  = idx;
    row.val  = val;
    return row;
  endfunction

  // No note held, none starting: only channel, offset and level show
  function automatic plan_row_t quiet_exp(plan_row_t row, int nib, int shown);
    row.known              = 1'b1;
    row.res                = '0;
    row.res.channel_nibble = 4'(nib);
    row.res.event_offset   = row.beat.block_end_offset;
    row.res.held_note      = -8'sd1;
    row.res.shown_level    = 16'(shown);
    return row;
  endfunction

  initial begin
    plan_row_t   plan[$];
    in_beat_t    b;
    int unsigned lo_e, hi_e, hcap, lf, cm, base;
    int          lo_w, hi_w, sens_w, note, len, pitch, roll, sent;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, defaults after reset: level floor 948, clarity floor 45516
    plan.push_back(quiet_exp(frame_row(0, 0, 0, 0, 0), 0, 0));
    plan.push_back(quiet_exp(frame_row(0, 'h7FFF, 'hFFFF, 'hFFFF, 'hFFF), 0, 'hFFFF));
    plan.push_back(frame_row(1, 60 * 256, 'hFFFF, 'h4000, 'h123));
    plan.push_back(frame_row(1, 60 * 256, 'hFFFF, 'h4000, 'h124));
    plan.push_back(frame_row(1, 64 * 256 + 100, 'hF000, 'h4000, 'h125));
    plan.push_back(frame_row(1, 64 * 256 - 100, 'hF000, 'h4100, 'h126));
    plan.push_back(frame_row(1, 64 * 256, 'hF000, 'h4000, 'h127));
    // range edges, then clarity and level exactly at their floors
    plan.push_back(frame_row(1, 2983, 'hFFFF, 'h3000, 'h200));
    plan.push_back(frame_row(1, 2982, 'hFFFF, 'h3000, 'h201));
    plan.push_back(frame_row(1, 27735, 'hFFFF, 'h3000, 'h202));
    plan.push_back(frame_row(1, 27736, 'hFFFF, 'h3000, 'h203));
    plan.push_back(frame_row(1, 64 * 256, 45516, 'h3000, 'h204));
    plan.push_back(frame_row(1, 64 * 256, 'hFFFF, 948, 'h205));
    // hold a note, sit out the refractory time, then an onset retrigger
    plan.push_back(frame_row(1, 64 * 256, 'hFFFF, 'h2000, 'h300));
    plan.push_back(frame_row(1, 64 * 256, 'hFFFF, 'h2000, 'h301));
    plan.push_back(frame_row(1, 64 * 256, 'hFFFF, 'h2000, 'h302));
    plan.push_back(frame_row(1, 64 * 256, 'hFFFF, 'h2000, 'h303));
    plan.push_back(frame_row(1, 64 * 256, 'hFFFF, 'h2000, 'h304));
    plan.push_back(frame_row(1, 64 * 256, 'hFFFF, 'hFFFF, 'h305));
    // top note: low note 127 lifts the range to 128, notes clamp at 127
    plan.push_back(reg_row(CFG_RESPONSE_MODE, MODE_QUICK));
    plan.push_back(reg_row(CFG_SENSITIVITY, 0));
    plan.push_back(reg_row(CFG_LOW_NOTE, 127));
    plan.push_back(reg_row(CFG_HIGH_NOTE, 0));
    plan.push_back(frame_row(1, 'h7FFF, 'hFFFF, 'h8000, 'h400));
    plan.push_back(frame_row(0, 0, 0, 0, 'h401));
    plan.push_back(frame_row(0, 0, 0, 0, 'h402));
    // channel below and above range
    plan.push_back(reg_row(CFG_MIDI_CHANNEL, 0));
    plan.push_back(quiet_exp(frame_row(0, 'h1234, 'h5555, 'h1234, 'h0AA), 0, 'h48D0));
    plan.push_back(reg_row(CFG_MIDI_CHANNEL, 31));
    plan.push_back(quiet_exp(frame_row(1, 'h2AAA, 'hAAAA, 'h4000, 'hFFF), 15, 'hFFFF));
    // spare response mode, sensitivity past 1.0, bottom note
    plan.push_back(reg_row(CFG_RESPONSE_MODE, MODE_SPARE));
    plan.push_back(reg_row(CFG_SENSITIVITY, 511));
    plan.push_back(reg_row(CFG_LOW_NOTE, 0));
    plan.push_back(reg_row(CFG_HIGH_NOTE, 127));
    plan.push_back(reg_row(CFG_MIDI_CHANNEL, 16));
    plan.push_back(frame_row(1, 0, 'h8001, 99, 'h500));
    plan.push_back(frame_row(1, 0, 'h8001, 99, 'h501));
    plan.push_back(frame_row(1, 'h7FFF, 'hFFFF, 'hFFFF, 'h502));
    plan.push_back(reg_row(CFG_SENSITIVITY, 256));
    plan.push_back(reg_row(CFG_RESPONSE_MODE, MODE_CAREFUL));
    plan.push_back(frame_row(1, 100 * 256, 'h8001, 99, 'h503));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_frame(plan[i].beat, plan[i].known, plan[i].res);
      end
    end

    // Random part: a fresh setting per phase, mostly runs of held notes
    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      write_reg(CFG_MIDI_CHANNEL, $urandom_range(0, 31));
      roll = $urandom_range(0, 9);
      lo_w = (roll == 0) ? 0 : (roll == 1) ? 127 : $urandom_range(0, 100);
      hi_w = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 127) : $urandom_range(lo_w, 127);
      roll = $urandom_range(0, 19);
      sens_w = (roll < 3) ? 0 : (roll < 6) ? $urandom_range(257, 511) :
               (roll < 8) ? 256 : $urandom_range(1, 255);
      write_reg(CFG_LOW_NOTE, lo_w);
      write_reg(CFG_HIGH_NOTE, hi_w);
      write_reg(CFG_RESPONSE_MODE, $urandom_range(0, 3));
      write_reg(CFG_SENSITIVITY, sens_w);
      calm = (ph == 4 || ph == 5);

      lo_e = cfg_lo;
      hi_e = (cfg_hi < cfg_lo + 1) ? cfg_lo + 1 : cfg_hi;
      hcap = (hi_e > 127) ? 127 : hi_e;
      lf   = level_floor_of(cfg_sens);
      cm   = clarity_min_of(cfg_sens);
      sent = 0;
      while (sent < PhaseFrames) begin
        roll = $urandom_range(0, 99);
        len  = $urandom_range(1, 8);
        note = $urandom_range(lo_e, hcap);
        base = ($urandom_range(0, 3) == 0) ? $urandom_range(lf + 1, 65535)
                                           : $urandom_range(lf + 1, lf + 6000);
        for (int k = 0; k < len && sent < PhaseFrames; k++) begin
          b.pitch_valid      = 1'($urandom);
          b.pitch_note       = 15'($urandom);
          b.clarity          = 16'($urandom);
          b.level            = 16'($urandom);
          b.block_end_offset = 12'($urandom);
          if (roll < 65) begin
            // voiced run around one note, the odd level jump for onsets
            pitch = note * 256 + $urandom_range(0, 240) - 120;
            if (pitch < 0) pitch = 0;
            if (pitch > 32767) pitch = 32767;
            b.pitch_valid = 1'b1;
            b.pitch_note  = 15'(pitch);
            b.clarity     = 16'($urandom_range(cm + 1, 65535));
            b.level       = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(40000, 65535))
                                                        : 16'(base);
          end else if (roll < 85) begin
            // silence: one reason to drop the frame
            case ($urandom_range(0, 2))
              0: b.pitch_valid = 1'b0;
              1: b.level = 16'($urandom_range(0, lf));
              default: b.clarity = 16'($urandom_range(0, cm));
            endcase
          end
          send_frame(b, 1'b0, '0);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (results_seen < frames_sent) @(posedge clk);
    repeat (8) @(posedge clk);
    if (awaited_results.size() != 0) mismatches += awaited_results.size();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
